FILE: hw/rtl/tmprof_pkg.sv
// Shared types and constants for the trapezoidal motion profile core.
`timescale 1ns / 1ps

package tmprof_pkg;

    // Default number of fraction bits of every fixed-point quantity.
    localparam int FRAC_BITS_DEF = 16;

    // Command selector of an input word.
    typedef enum logic [1:0] {
        OP_TICK        = 2'd0,
        OP_START_LIMIT = 2'd1,
        OP_START_TIME  = 2'd2,
        OP_NOP         = 2'd3
    } cmd_op_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_MAX_VELOCITY = 2'd0,
        CFG_MAX_ACCEL    = 2'd1,
        CFG_TICK_PERIOD  = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] displacement;
        logic signed [31:0] accel_time;
        logic [30:0]        cruise_time;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] velocity;
        logic signed [31:0] acceleration;
        logic signed [31:0] position;
        logic               moving;
        logic               command_taken;
    } res_t;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0] {
        AR_MUL  = 2'd0,
        AR_DIV  = 2'd1,
        AR_SQRT = 2'd2
    } arith_op_t;

    typedef struct packed {
        logic        start;
        arith_op_t   op;
        logic [63:0] opa;
        logic [31:0] opb;
    } arith_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } arith_rsp_t;

    // Sequencer states of the top level.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_L_PROD,
        ST_L_ROOT,
        ST_L_TACC,
        ST_L_VSQ,
        ST_L_DACC,
        ST_L_TCR,
        ST_P_PEAK,
        ST_P_ACC,
        ST_COMMIT,
        ST_T_PROD,
        ST_T_STEP,
        ST_EMIT
    } state_t;

endpackage

FILE: hw/rtl/tmprof_arith.sv
// Shared arithmetic unit: registered multiply, bit-serial divide and square root.
`timescale 1ns / 1ps

module tmprof_arith (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tmprof_pkg::arith_req_t req,
    output tmprof_pkg::arith_rsp_t rsp
);
    import tmprof_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    arith_op_t   op_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] num_reg;
    logic [31:0] div_reg;
    logic [35:0] rem_reg;
    logic [63:0] quo_reg;

    logic [63:0] mul_prod;
    logic [32:0] div_sh;
    logic [32:0] div_diff;
    logic        div_ge;
    logic [35:0] sq_sh;
    logic [35:0] sq_trial;
    logic        sq_ge;

    assign mul_prod = req.opa[31:0] * req.opb;
    assign div_sh   = {rem_reg[31:0], num_reg[63]};
    assign div_ge   = div_sh >= {1'b0, div_reg};
    assign div_diff = div_sh - {1'b0, div_reg};
    assign sq_sh    = {rem_reg[33:0], num_reg[63:62]};
    assign sq_trial = {2'b00, quo_reg[31:0], 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg && req.start)
            begin
                if (req.op == AR_MUL)
                    done_reg <= 1'b1;
                else
                    busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == 6'd0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && req.start)
        begin
            op_reg  <= req.op;
            num_reg <= req.opa;
            div_reg <= req.opb;
            rem_reg <= '0;
            unique case (req.op)
                AR_MUL:
                begin
                    quo_reg <= mul_prod;
                    cnt_reg <= 6'd0;
                end
                AR_DIV:
                begin
                    quo_reg <= '0;
                    cnt_reg <= 6'd63;
                end
                default:
                begin
                    quo_reg <= '0;
                    cnt_reg <= 6'd31;
                end
            endcase
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (op_reg == AR_DIV)
            begin
                rem_reg <= div_ge ? {3'b000, div_diff} : {3'b000, div_sh};
                quo_reg <= {quo_reg[62:0], div_ge};
                num_reg <= {num_reg[62:0], 1'b0};
            end
            else
            begin
                rem_reg <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
                quo_reg <= {quo_reg[62:0], sq_ge};
                num_reg <= {num_reg[61:0], 2'b00};
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = quo_reg;

    // The partial remainder of a division always stays below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && op_reg == AR_DIV |-> rem_reg[32:0] < {1'b0, div_reg})
        else $error("divide remainder not below divisor");

    // The square root remainder never exceeds twice the partial root.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && op_reg == AR_SQRT |-> rem_reg <= {3'b000, quo_reg[31:0], 1'b0})
        else $error("square root remainder out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg || req.start))
        else $error("arithmetic done without a running operation");

endmodule

FILE: hw/rtl/trapezoidal_motion_profile_core.sv
// Top level of the trapezoidal motion profile core: sequencer, profile state and ports.
// The core generates a trapezoidal velocity profile in signed fixed point with FRAC_BITS
// fraction bits. A limit start word sets the peak velocity to the lesser of max_velocity
// and sqrt(max_accel * |d|) and derives the end times of the acceleration, cruise and
// deceleration segments; a time start word derives peak velocity and acceleration from
// the given segment times. Start words with a displacement below one millisecond worth of
// LSBs, or time starts with a nonpositive acceleration time, are ignored. Each tick word
// returns signed velocity, acceleration and saturating position, advancing time in a move.
// Every accepted word returns exactly one result word. One word is processed at a time:
// cmd_stall is high from acceptance until the result has entered the output register,
// which may still hold the previous result while the next word is being worked on.
// All arithmetic runs through one shared unit with a registered multiplier, a one bit per
// cycle divider (64 steps) and a two bits per cycle square root (32 steps). That unit
// sets the time from one accepted word to the next, with the output free: an active tick
// uses two multiplies, a time start two divisions, a limit start two multiplies, a root
// and two divisions, plus one with a cruise segment; an idle tick or ignored word, none.
// Configuration writes are always ready and take effect at once; they are meant to be
// done while the core is idle.
`timescale 1ns / 1ps

module trapezoidal_motion_profile_core #(
    parameter int FRAC_BITS = tmprof_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  tmprof_pkg::cmd_t cmd,
    output logic             res_valid,
    input  logic             res_stall,
    output tmprof_pkg::res_t res,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data
);
    import tmprof_pkg::*;

    // One unit in fixed point, and the smallest displacement a start word may carry.
    localparam logic [63:0] ONE_Q       = 64'd1 << FRAC_BITS;
    localparam logic [63:0] MILLI_Q     = (ONE_Q + 64'd500) / 64'd1000;
    localparam logic [31:0] MIN_MAG     = (MILLI_Q == 64'd0) ? 32'd1 : MILLI_Q[31:0];
    localparam logic [30:0] VEL_RST     = ONE_Q[30:0];
    localparam logic [15:0] TICK_RST    = MILLI_Q[15:0];

    function automatic logic [31:0] sat32(input logic [64:0] v);
        return (v > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [30:0] sat31(input logic [63:0] v);
        return (v > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : v[30:0];
    endfunction

    // Sequencer and handshake state.
    state_t      state_reg, state_next;
    logic        launched_reg, launched_next;
    logic        res_valid_reg;

    // Configuration registers.
    logic [30:0] max_vel_reg, max_acc_reg;
    logic [15:0] tick_reg;

    // Profile state.
    logic        moving_reg, moving_next;
    logic        neg_reg, neg_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic [30:0] peak_reg, peak_next;
    logic [30:0] acc_use_reg, acc_use_next;
    logic [31:0] ta_end_reg, ta_end_next;
    logic [31:0] tc_end_reg, tc_end_next;
    logic [31:0] td_end_reg, td_end_next;
    logic [31:0] vel_now_reg, vel_now_next;
    logic [31:0] acc_now_reg, acc_now_next;
    logic [31:0] pos_now_reg, pos_now_next;

    // Working registers of the current word.
    cmd_t        in_reg;
    logic [30:0] v_reg, v_next;
    logic [31:0] ta_reg, ta_next;
    logic [63:0] tmp_reg, tmp_next;
    logic        taken_reg, taken_next;
    res_t        res_reg;

    arith_req_t  arith_req;
    arith_rsp_t  arith_rsp;

    // Effective register values: a zero register acts as one LSB.
    logic [30:0] acc_eff, vel_lim;
    logic [15:0] dt_eff;

    logic        d_neg;
    logic [31:0] dmag;
    logic        small_move, bad_ta;
    logic [30:0] ta_u;
    logic [31:0] time_sum;
    logic [63:0] twice_dacc;
    logic        cruise_left;
    logic        in_acc, in_cru, in_dec;
    logic [63:0] scaled;
    logic [63:0] root;
    logic [64:0] cruise_sum;
    logic [31:0] cruise_sat;
    logic [64:0] decel_sum;
    logic [32:0] tdecel_sum;
    logic signed [63:0] pos_ext, pos_sum;
    logic [31:0] pos_sat;
    logic [32:0] elapsed_sum;
    logic        res_free;

    tmprof_arith u_arith (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (arith_req),
        .rsp  (arith_rsp)
    );

    assign acc_eff = (max_acc_reg == '0) ? 31'd1 : max_acc_reg;
    assign vel_lim = (max_vel_reg == '0) ? 31'd1 : max_vel_reg;
    assign dt_eff  = (tick_reg == '0) ? 16'd1 : tick_reg;

    // The most negative displacement maps onto a magnitude of 2^31 by itself.
    assign d_neg      = in_reg.displacement[31];
    assign dmag       = d_neg ? (~in_reg.displacement + 32'd1) : in_reg.displacement;
    assign small_move = (dmag < MIN_MAG) || (dmag == 32'd0);
    assign bad_ta     = in_reg.accel_time[31] || (in_reg.accel_time == 32'sd0);
    assign ta_u       = in_reg.accel_time[30:0];
    assign time_sum   = {1'b0, ta_u} + {1'b0, in_reg.cruise_time};

    // Cruise remains when the displacement exceeds twice the acceleration distance.
    assign twice_dacc  = {arith_rsp.result[62:0], 1'b0};
    assign cruise_left = {32'd0, dmag} > twice_dacc;

    assign root   = arith_rsp.result;
    assign scaled = arith_rsp.result >> FRAC_BITS;

    assign in_acc = elapsed_reg < ta_end_reg;
    assign in_cru = elapsed_reg < tc_end_reg;
    assign in_dec = elapsed_reg < td_end_reg;

    // Segment end times of a limit start.
    assign cruise_sum = {33'd0, ta_reg} + {1'b0, tmp_reg};
    assign cruise_sat = sat32(cruise_sum);
    assign decel_sum  = {33'd0, cruise_sat} + {33'd0, ta_reg};
    // Deceleration end of a time start.
    assign tdecel_sum = {1'b0, time_sum} + {2'b00, ta_u};

    // Position step of a tick, saturated to the signed 32-bit range.
    assign pos_ext = {{32{pos_now_reg[31]}}, pos_now_reg};
    assign pos_sum = neg_reg ? (pos_ext - $signed(scaled)) : (pos_ext + $signed(scaled));
    always_comb
    begin
        if (pos_sum > 64'sd2147483647)
            pos_sat = 32'h7FFF_FFFF;
        else if (pos_sum < -64'sd2147483648)
            pos_sat = 32'h8000_0000;
        else
            pos_sat = pos_sum[31:0];
    end
    assign elapsed_sum = {1'b0, elapsed_reg} + {17'd0, dt_eff};

    assign res_free = !res_valid_reg || !res_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (cmd_valid)
                    state_next = ST_DECODE;
            ST_DECODE:
                unique case (in_reg.op)
                    OP_START_LIMIT: state_next = small_move ? ST_EMIT : ST_L_PROD;
                    OP_START_TIME:  state_next = (small_move || bad_ta) ? ST_EMIT : ST_P_PEAK;
                    OP_TICK:        state_next = moving_reg ? ST_T_PROD : ST_EMIT;
                    default:        state_next = ST_EMIT;
                endcase
            ST_L_PROD: if (arith_rsp.done) state_next = ST_L_ROOT;
            ST_L_ROOT: if (arith_rsp.done) state_next = ST_L_TACC;
            ST_L_TACC: if (arith_rsp.done) state_next = ST_L_VSQ;
            ST_L_VSQ:  if (arith_rsp.done) state_next = ST_L_DACC;
            ST_L_DACC:
                if (arith_rsp.done)
                    state_next = cruise_left ? ST_L_TCR : ST_COMMIT;
            ST_L_TCR:  if (arith_rsp.done) state_next = ST_COMMIT;
            ST_P_PEAK: if (arith_rsp.done) state_next = ST_P_ACC;
            ST_P_ACC:  if (arith_rsp.done) state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_EMIT;
            ST_T_PROD: if (arith_rsp.done) state_next = ST_T_STEP;
            ST_T_STEP: if (arith_rsp.done) state_next = ST_EMIT;
            ST_EMIT:   if (res_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Unit requests and datapath updates.
    always_comb
    begin
        arith_req     = '0;
        launched_next = launched_reg;
        moving_next   = moving_reg;
        neg_next      = neg_reg;
        elapsed_next  = elapsed_reg;
        peak_next     = peak_reg;
        acc_use_next  = acc_use_reg;
        ta_end_next   = ta_end_reg;
        tc_end_next   = tc_end_reg;
        td_end_next   = td_end_reg;
        vel_now_next  = vel_now_reg;
        acc_now_next  = acc_now_reg;
        pos_now_next  = pos_now_reg;
        v_next        = v_reg;
        ta_next       = ta_reg;
        tmp_next      = tmp_reg;
        taken_next    = taken_reg;

        // Each compute state launches the unit once and waits for its done pulse.
        arith_req.start = !launched_reg;

        unique case (state_reg)
            ST_IDLE:
                arith_req.start = 1'b0;
            ST_DECODE:
            begin
                arith_req.start = 1'b0;
                taken_next      = 1'b0;
                if (in_reg.op == OP_TICK && !moving_reg)
                begin
                    vel_now_next = '0;
                    acc_now_next = '0;
                end
            end
            ST_L_PROD:
            begin
                arith_req.op  = AR_MUL;
                arith_req.opa = {33'd0, acc_eff};
                arith_req.opb = dmag;
                if (arith_rsp.done)
                    tmp_next = arith_rsp.result;
            end
            ST_L_ROOT:
            begin
                arith_req.op  = AR_SQRT;
                arith_req.opa = tmp_reg;
                if (arith_rsp.done)
                begin
                    if (root > {33'd0, vel_lim})
                        v_next = vel_lim;
                    else if (root == 64'd0)
                        v_next = 31'd1;
                    else
                        v_next = root[30:0];
                end
            end
            ST_L_TACC:
            begin
                arith_req.op  = AR_DIV;
                arith_req.opa = {33'd0, v_reg} << FRAC_BITS;
                arith_req.opb = {1'b0, acc_eff};
                if (arith_rsp.done)
                    ta_next = sat32({1'b0, arith_rsp.result});
            end
            ST_L_VSQ:
            begin
                arith_req.op  = AR_MUL;
                arith_req.opa = {33'd0, v_reg};
                arith_req.opb = {1'b0, v_reg};
                if (arith_rsp.done)
                    tmp_next = arith_rsp.result;
            end
            ST_L_DACC:
            begin
                arith_req.op  = AR_DIV;
                arith_req.opa = tmp_reg;
                arith_req.opb = {acc_eff, 1'b0};
                if (arith_rsp.done)
                    tmp_next = cruise_left ? ({32'd0, dmag} - twice_dacc) : 64'd0;
            end
            ST_L_TCR:
            begin
                arith_req.op  = AR_DIV;
                arith_req.opa = tmp_reg << FRAC_BITS;
                arith_req.opb = {1'b0, v_reg};
                if (arith_rsp.done)
                    tmp_next = arith_rsp.result;
            end
            ST_P_PEAK:
            begin
                arith_req.op  = AR_DIV;
                arith_req.opa = {32'd0, dmag} << FRAC_BITS;
                arith_req.opb = time_sum;
                if (arith_rsp.done)
                    v_next = sat31(arith_rsp.result);
            end
            ST_P_ACC:
            begin
                arith_req.op  = AR_DIV;
                arith_req.opa = {33'd0, v_reg} << FRAC_BITS;
                arith_req.opb = {1'b0, ta_u};
                if (arith_rsp.done)
                    tmp_next = {33'd0, sat31(arith_rsp.result)};
            end
            ST_COMMIT:
            begin
                arith_req.start = 1'b0;
                neg_next        = d_neg;
                elapsed_next    = '0;
                vel_now_next    = '0;
                acc_now_next    = '0;
                pos_now_next    = '0;
                moving_next     = 1'b1;
                taken_next      = 1'b1;
                peak_next       = v_reg;
                if (in_reg.op == OP_START_LIMIT)
                begin
                    acc_use_next = acc_eff;
                    ta_end_next  = ta_reg;
                    tc_end_next  = cruise_sat;
                    td_end_next  = sat32(decel_sum);
                end
                else
                begin
                    acc_use_next = tmp_reg[30:0];
                    ta_end_next  = {1'b0, ta_u};
                    tc_end_next  = time_sum;
                    td_end_next  = sat32({32'd0, tdecel_sum});
                end
            end
            ST_T_PROD:
            begin
                arith_req.op  = AR_MUL;
                arith_req.opa = {33'd0, acc_use_reg};
                arith_req.opb = in_acc ? elapsed_reg : (elapsed_reg - tc_end_reg);
                if (arith_rsp.done)
                begin
                    // Ramp up, cruise, ramp down, or the final tick of the move.
                    priority if (in_acc)
                    begin
                        v_next = (scaled > {33'd0, peak_reg}) ? peak_reg : scaled[30:0];
                        acc_now_next = neg_reg ? (~{1'b0, acc_use_reg} + 32'd1)
                                               : {1'b0, acc_use_reg};
                    end
                    else if (in_cru)
                    begin
                        v_next       = peak_reg;
                        acc_now_next = '0;
                    end
                    else if (in_dec)
                    begin
                        v_next = (scaled > {33'd0, peak_reg}) ? 31'd0
                                                              : (peak_reg - scaled[30:0]);
                        acc_now_next = neg_reg ? {1'b0, acc_use_reg}
                                               : (~{1'b0, acc_use_reg} + 32'd1);
                    end
                    else
                    begin
                        v_next       = '0;
                        acc_now_next = '0;
                        moving_next  = 1'b0;
                    end
                end
            end
            ST_T_STEP:
            begin
                arith_req.op  = AR_MUL;
                arith_req.opa = {33'd0, v_reg};
                arith_req.opb = {16'd0, dt_eff};
                vel_now_next  = neg_reg ? (~{1'b0, v_reg} + 32'd1) : {1'b0, v_reg};
                if (arith_rsp.done)
                begin
                    pos_now_next = pos_sat;
                    elapsed_next = sat32({32'd0, elapsed_sum});
                end
            end
            ST_EMIT:
                arith_req.start = 1'b0;
            default:
                arith_req.start = 1'b0;
        endcase

        if (arith_rsp.done)
            launched_next = 1'b0;
        else if (arith_req.start)
            launched_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launched_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            max_vel_reg   <= VEL_RST;
            max_acc_reg   <= VEL_RST;
            tick_reg      <= TICK_RST;
            moving_reg    <= 1'b0;
            neg_reg       <= 1'b0;
            elapsed_reg   <= '0;
            peak_reg      <= '0;
            acc_use_reg   <= '0;
            ta_end_reg    <= '0;
            tc_end_reg    <= '0;
            td_end_reg    <= '0;
            vel_now_reg   <= '0;
            acc_now_reg   <= '0;
            pos_now_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
            moving_reg   <= moving_next;
            neg_reg      <= neg_next;
            elapsed_reg  <= elapsed_next;
            peak_reg     <= peak_next;
            acc_use_reg  <= acc_use_next;
            ta_end_reg   <= ta_end_next;
            tc_end_reg   <= tc_end_next;
            td_end_reg   <= td_end_next;
            vel_now_reg  <= vel_now_next;
            acc_now_reg  <= acc_now_next;
            pos_now_reg  <= pos_now_next;

            if (state_reg == ST_EMIT && res_free)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_MAX_VELOCITY: max_vel_reg <= cfg_data[30:0];
                    CFG_MAX_ACCEL:    max_acc_reg <= cfg_data[30:0];
                    CFG_TICK_PERIOD:  tick_reg    <= cfg_data[15:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && cmd_valid)
            in_reg <= cmd;
        v_reg     <= v_next;
        ta_reg    <= ta_next;
        tmp_reg   <= tmp_next;
        taken_reg <= taken_next;
        if (state_reg == ST_EMIT && res_free)
        begin
            res_reg.velocity      <= vel_now_reg;
            res_reg.acceleration  <= acc_now_reg;
            res_reg.position      <= pos_now_reg;
            res_reg.moving        <= moving_reg;
            res_reg.command_taken <= taken_reg;
        end
    end

    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign cfg_ready = 1'b1;

    // Segment end times are ordered at all times.
    assert property (@(posedge clk) disable iff (!rst_n)
        tc_end_reg >= ta_end_reg && td_end_reg >= tc_end_reg)
        else $error("segment end times out of order");

    // A taken start word always reports an active move.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.command_taken |-> res.moving)
        else $error("start word taken without an active move");

    assert property (@(posedge clk) disable iff (!rst_n)
        arith_rsp.done |-> state_reg != ST_IDLE && state_reg != ST_EMIT)
        else $error("arithmetic result arrived outside a compute state");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !launched_reg)
        else $error("unit launch flag left set in idle");

endmodule

FILE: test/tb_trapezoidal_motion_profile_core.sv
// Self-checking testbench for the trapezoidal motion profile core.
`timescale 1ns / 1ps

module tb_trapezoidal_motion_profile_core;
    import tmprof_pkg::*;

    localparam int FB = 16;
    localparam logic [31:0] MAX31 = 32'h7FFF_FFFF;
    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
    // Smallest accepted displacement magnitude: one millisecond of LSBs.
    localparam logic [31:0] MIN_DISP = 32'd66;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic res_valid;
    logic res_stall;
    res_t res;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    trapezoidal_motion_profile_core uut (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
        .res_valid(res_valid), .res_stall(res_stall), .res(res),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predicted configuration and profile state.
    logic [31:0] lim_vel, lim_acc, dt_reg;
    logic        run_flag, dir_neg;
    logic [31:0] t_now, v_peak, a_move, t_acc_end, t_cru_end, t_dec_end;
    logic [31:0] v_out, a_out, p_out;

    cmd_t pending_words[$];
    res_t expected_words[$];
    int   mismatches = 0;
    int   send_idle_pct;
    int   recv_stall_pct;
    logic hold_sender;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] isqrt(logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] clip31(logic [63:0] v);
        return (v > 64'(MAX31)) ? MAX31 : v[31:0];
    endfunction

    function automatic logic [31:0] clip32(logic [63:0] v);
        return (v > 64'(MAX32)) ? MAX32 : v[31:0];
    endfunction

    function automatic logic [31:0] at_least_one(logic [31:0] v);
        return (v == 0) ? 32'd1 : v;
    endfunction

    function automatic res_t snapshot(logic taken);
        res_t r;
        r.velocity = v_out;
        r.acceleration = a_out;
        r.position = p_out;
        r.moving = run_flag;
        r.command_taken = taken;
        return r;
    endfunction

    function automatic void clear_profile();
        run_flag = 0; dir_neg = 0;
        t_now = 0; v_peak = 0; a_move = 0;
        t_acc_end = 0; t_cru_end = 0; t_dec_end = 0;
        v_out = 0; a_out = 0; p_out = 0;
    endfunction

    function automatic void arm_move(logic neg);
        dir_neg = neg;
        t_now = 0; v_out = 0; a_out = 0; p_out = 0;
        run_flag = 1;
    endfunction

    // Computes the result of one command word and advances the predicted state.
    function automatic res_t profile_step(cmd_t w);
        logic [31:0] d_raw;
        logic [31:0] d_abs;
        logic        d_neg, acc_neg;
        logic [63:0] d_mag, a, vm, v, ta, dacc, tcr, tcv, t, dec, vel, acc, step, dt;
        logic signed [63:0] dcr, pos;
        d_raw = w.displacement;
        d_neg = d_raw[31];
        // Negate at 32 bits so the most negative value maps onto 2^31.
        d_abs = d_neg ? -d_raw : d_raw;
        d_mag = 64'(d_abs);
        if (w.op == OP_START_LIMIT || w.op == OP_START_TIME)
        begin
            if (d_mag < 64'(MIN_DISP)) return snapshot(0);
            if (w.op == OP_START_LIMIT)
            begin
                a = 64'(at_least_one(lim_acc));
                vm = 64'(at_least_one(lim_vel));
                v = isqrt(a * d_mag);
                if (v > vm) v = vm;
                if (v == 0) v = 1;
                ta = 64'(clip32((v << FB) / a));
                dacc = (v * v) / (2 * a);
                dcr = $signed(d_mag) - $signed(2 * dacc);
                tcr = (dcr > 0) ? ((64'(dcr) << FB) / v) : 0;
                arm_move(d_neg);
                v_peak = v[31:0];
                a_move = a[31:0];
                t_acc_end = ta[31:0];
                t_cru_end = clip32(ta + tcr);
                t_dec_end = clip32(64'(t_cru_end) + ta);
            end
            else
            begin
                if (w.accel_time <= 0) return snapshot(0);
                ta = 64'(w.accel_time);
                tcv = 64'(w.cruise_time);
                v = 64'(clip31((d_mag << FB) / (ta + tcv)));
                arm_move(d_neg);
                v_peak = v[31:0];
                a_move = clip31((v << FB) / ta);
                t_acc_end = ta[31:0];
                t_cru_end = clip32(ta + tcv);
                t_dec_end = clip32(ta + tcv + ta);
            end
            return snapshot(1);
        end
        if (w.op == OP_NOP) return snapshot(0);
        if (!run_flag)
        begin
            v_out = 0;
            a_out = 0;
            return snapshot(0);
        end
        t = 64'(t_now);
        a = 64'(a_move);
        v = 64'(v_peak);
        dt = 64'(at_least_one(dt_reg));
        acc_neg = dir_neg;
        if (t < 64'(t_acc_end))
        begin
            vel = (a * t) >> FB;
            if (vel > v) vel = v;
            acc = a;
        end
        else if (t < 64'(t_cru_end))
        begin
            vel = v;
            acc = 0;
        end
        else if (t < 64'(t_dec_end))
        begin
            dec = (a * (t - 64'(t_cru_end))) >> FB;
            vel = (dec > v) ? 0 : v - dec;
            acc = a;
            acc_neg = !dir_neg;
        end
        else
        begin
            vel = 0;
            acc = 0;
            run_flag = 0;
        end
        v_out = dir_neg ? -vel[31:0] : vel[31:0];
        a_out = acc_neg ? -acc[31:0] : acc[31:0];
        step = (vel * dt) >> FB;
        pos = 64'($signed(p_out));
        if (dir_neg) pos = pos - $signed(step); else pos = pos + $signed(step);
        if (pos > 64'sd2147483647) pos = 64'sd2147483647;
        if (pos < -64'sd2147483648) pos = -64'sd2147483648;
        p_out = pos[31:0];
        t_now = clip32(64'(t_now) + dt);
        return snapshot(0);
    endfunction

    // Driver: presents queued words; valid is raised without looking at stall and held while stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd <= '0;
            clear_profile();
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
                expected_words.push_back(profile_step(cmd));
            if (!cmd_valid || !cmd_stall)
            begin
                if (pending_words.size() > 0 && !hold_sender &&
                    $urandom_range(99, 0) >= send_idle_pct)
                begin
                    cmd <= pending_words.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // Monitor: compares every accepted result word with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        res_t exp_w;
        if (!rst_n)
            res_stall <= 1'b0;
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result word %h", res);
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (res !== exp_w)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: exp v=%0d a=%0d p=%0d m=%b c=%b,",
                                exp_w.velocity, exp_w.acceleration, exp_w.position,
                                exp_w.moving, exp_w.command_taken,
                                " got v=%0d a=%0d p=%0d m=%b c=%b",
                                res.velocity, res.acceleration, res.position,
                                res.moving, res.command_taken);
                    end
                end
            end
            res_stall <= ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MAX_VELOCITY: lim_vel = value & MAX31;
            CFG_MAX_ACCEL:    lim_acc = value & MAX31;
            CFG_TICK_PERIOD:  dt_reg = value & 32'hFFFF;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || cmd_valid || cmd_stall ||
               expected_words.size() > 0)
            @(posedge clk);
        // Ignored words give no extra work, but allow the output register to settle.
        repeat (20) @(posedge clk);
    endtask

    function automatic cmd_t make_word(cmd_op_t op, logic [31:0] d, logic [31:0] ta,
                                       logic [30:0] tc);
        cmd_t w;
        w.op = op;
        w.displacement = d;
        w.accel_time = ta;
        w.cruise_time = tc;
        return w;
    endfunction

    // Random displacement of either sign, mostly modest so moves finish in a few dozen ticks.
    function automatic logic [31:0] rand_disp();
        logic [31:0] d;
        case ($urandom_range(9, 0))
            0: d = $urandom();
            1: d = $urandom_range(70, 60);
            default: d = $urandom_range(32'h0004_0000, 32'h0000_0100);
        endcase
        if ($urandom_range(1, 0)) d = -d;
        return d;
    endfunction

    // One move: a start word followed by 2 to 30 further words, mostly ticks and now and then a random word.
    task automatic queue_move();
        int n;
        if ($urandom_range(1, 0))
            pending_words.push_back(make_word(OP_START_LIMIT, rand_disp(), $urandom(),
                                              31'($urandom())));
        else
            pending_words.push_back(make_word(OP_START_TIME, rand_disp(),
                                              $urandom_range(32'h0002_0000, 1),
                                              31'($urandom_range(32'h0002_0000, 0))));
        n = $urandom_range(30, 2);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(15, 0) == 0)
                pending_words.push_back(make_word(cmd_op_t'($urandom_range(3, 0)),
                                                  $urandom(), $urandom(),
                                                  31'($urandom())));
            else
                pending_words.push_back(make_word(OP_TICK, $urandom(), $urandom(),
                                                  31'($urandom())));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MAX_VELOCITY;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_sender = 1'b0;
        lim_vel = 32'h0001_0000;
        lim_acc = 32'h0001_0000;
        dt_reg = 32'd66;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: field extremes, every selector, rejected starts.
        pending_words.push_back(make_word(OP_TICK, 0, 0, 0));
        pending_words.push_back(make_word(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
        pending_words.push_back(make_word(OP_START_LIMIT, 0, 0, 0));
        pending_words.push_back(make_word(OP_START_LIMIT, 65, 0, 0));
        pending_words.push_back(make_word(OP_START_LIMIT, -65, 0, 0));
        pending_words.push_back(make_word(OP_START_TIME, 32'h0001_0000, 0, 5));
        pending_words.push_back(make_word(OP_START_TIME, 32'h0001_0000, 32'h8000_0000, 5));
        pending_words.push_back(make_word(OP_START_LIMIT, 66, 0, 0));
        for (int i = 0; i < 4; i++) pending_words.push_back(make_word(OP_TICK, 0, 0, 0));
        pending_words.push_back(make_word(OP_START_LIMIT, 32'h8000_0000, 0, 0));
        pending_words.push_back(make_word(OP_TICK, 0, 0, 0));
        pending_words.push_back(make_word(OP_START_LIMIT, 32'h7FFF_FFFF, 0, 0));
        pending_words.push_back(make_word(OP_TICK, 0, 0, 0));
        pending_words.push_back(make_word(OP_START_TIME, 32'h8000_0000, 1, 31'h7FFF_FFFF));
        pending_words.push_back(make_word(OP_TICK, 0, 0, 0));
        pending_words.push_back(make_word(OP_START_TIME, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
        pending_words.push_back(make_word(OP_TICK, 0, 0, 0));
        pending_words.push_back(make_word(OP_START_TIME, -32'h0001_0000, 32'd100, 31'd50));
        for (int i = 0; i < 5; i++) pending_words.push_back(make_word(OP_TICK, 0, 0, 0));
        drain();

        // Random phases, each under its own register setting and idling mix.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin write_reg(CFG_MAX_VELOCITY, 32'h0004_0000);
                         write_reg(CFG_MAX_ACCEL, 32'h0010_0000);
                         write_reg(CFG_TICK_PERIOD, 32'd6554); end
                1: begin write_reg(CFG_MAX_VELOCITY, 32'hFFFF_FFFF);
                         write_reg(CFG_MAX_ACCEL, 32'hFFFF_FFFF);
                         write_reg(CFG_TICK_PERIOD, 32'h0000_FFFF); end
                2: begin write_reg(CFG_MAX_VELOCITY, 0);
                         write_reg(CFG_MAX_ACCEL, 0);
                         write_reg(CFG_TICK_PERIOD, 0); end
                3: begin write_reg(CFG_MAX_VELOCITY, 1);
                         write_reg(CFG_MAX_ACCEL, 1);
                         write_reg(CFG_TICK_PERIOD, 1); end
                default: begin write_reg(CFG_MAX_VELOCITY, $urandom_range(32'h0010_0000, 1));
                         write_reg(CFG_MAX_ACCEL, $urandom_range(32'h0040_0000, 1));
                         write_reg(CFG_TICK_PERIOD, $urandom_range(16'hFFFF, 256)); end
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            while (pending_words.size() < 135)
                queue_move();
            // Midway through one phase the sender holds until all results are in.
            if (ph == 5)
            begin
                while (pending_words.size() > 70) @(posedge clk);
                hold_sender = 1'b1;
                while (cmd_valid || cmd_stall || expected_words.size() > 0)
                    @(posedge clk);
                hold_sender = 1'b0;
            end
            drain();
        end

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
